// ----- rtl/fwsk_pkg.sv -----
// ----------------------------------------------------------------------------
// fwsk_pkg
// Shared types, constants and helper functions for the four-wheel-steer
// kinematics pipeline.
// ----------------------------------------------------------------------------
package fwsk_pkg;

  // Default CORDIC depth
  localparam int CORDIC_STAGES_DEF = 16;

  // Datapath widths
  localparam int CW = 62;   // CORDIC x/y width
  localparam int ZW = 32;   // CORDIC angle width (Q30)
  localparam int DW = 56;   // divisor width (radius product << 8)

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_ENABLED     = 3'd0;
  localparam logic [2:0] REG_TRACK_WIDTH = 3'd1;
  localparam logic [2:0] REG_TRACK_SCALE = 3'd2;
  localparam logic [2:0] REG_BASE_RADIUS = 3'd3;
  localparam logic [2:0] REG_FRONT_SCALE = 3'd4;
  localparam logic [2:0] REG_REAR_SCALE  = 3'd5;

  // Register reset values
  localparam logic [23:0] TRACK_WIDTH_RST = 24'd32768;
  localparam logic [23:0] TRACK_SCALE_RST = 24'd65536;
  localparam logic [23:0] BASE_RADIUS_RST = 24'd6554;
  localparam logic [23:0] AXLE_SCALE_RST  = 24'd65536;

  // Angle constants
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
  localparam logic [16:0] SMALL_ANGLE_Q16 = 17'd655;

  // atan(2^-i) in Q30, truncated
  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127
  };

  // Metadata carried alongside the vectoring chain
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [48:0] n;
    logic               zero_n;
    logic               zero_vx;
    logic               neg;
  } axle_meta_t;

  // Flags carried alongside the divider chain
  typedef struct packed {
    logic neg;
    logic pzero;
    logic sat;
  } div_flags_t;

  // CORDIC gain compensation constant for a given stage count
  function automatic logic [29:0] kq_const(input int s);
    longint unsigned v;
    v = 64'd434688583 + (64'd1 << (2 * s - 1));
    return 30'(64'd652032874 + (v >> (2 * s)));
  endfunction

  // One normalisation step: shift both words left by k when the top k bits
  // of their union are clear
  function automatic logic [111:0] norm_step(input logic [55:0] x,
                                             input logic [55:0] y,
                                             input int k);
    logic [55:0] ones;
    logic [55:0] msk;
    ones = '1;
    msk  = ~(ones >> k);
    if (((x | y) & msk) == '0) begin
      return {x << k, y << k};
    end
    return {x, y};
  endfunction

endpackage

// ----- rtl/fwsk_channels.sv -----
// ----------------------------------------------------------------------------
// fwsk channels
// Valid/ready channel interfaces for commands, results and configuration.
// ----------------------------------------------------------------------------
interface fwsk_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_forward;
  logic signed [31:0] vel_lateral;
  logic signed [31:0] yaw_rate;
  modport source (output valid, output vel_forward, output vel_lateral,
                  output yaw_rate, input ready);
  modport sink   (input valid, input vel_forward, input vel_lateral,
                  input yaw_rate, output ready);
endinterface

interface fwsk_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] front_wheel_speed;
  logic signed [31:0] rear_wheel_speed;
  logic signed [17:0] front_steer_angle;
  logic signed [17:0] rear_steer_angle;
  modport source (output valid, output front_wheel_speed, output rear_wheel_speed,
                  output front_steer_angle, output rear_steer_angle, input ready);
  modport sink   (input valid, input front_wheel_speed, input rear_wheel_speed,
                  input front_steer_angle, input rear_steer_angle, output ready);
endinterface

interface fwsk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/fwsk_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// fwsk_cordic_cell
// One CORDIC iteration, registered; vectoring or rotation mode.
// ----------------------------------------------------------------------------
module fwsk_cordic_cell
  import fwsk_pkg::*;
#(
  parameter int   I      = 0,
  parameter logic ROTATE = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] a;
  logic                 ccw;

  // Direction from the angle residue or the sign of y
  always_comb begin
    xs  = x_in >>> I;
    ys  = y_in >>> I;
    a   = ZW'(ATAN_TAB[I]);
    ccw = ROTATE ? !z_in[ZW-1] : y_in[CW-1];
  end

  // Advance one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        x <= x_in - ys;
        y <= y_in + xs;
        z <= z_in - a;
      end else begin
        x <= x_in + ys;
        y <= y_in - xs;
        z <= z_in + a;
      end
    end
  end

endmodule

// ----- rtl/fwsk_div_cell.sv -----
// ----------------------------------------------------------------------------
// fwsk_div_cell
// One restoring division step, registered; yields one quotient bit.
// ----------------------------------------------------------------------------
module fwsk_div_cell
  import fwsk_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d,
  input  logic [DW-1:0] rem_in,
  input  logic [31:0]   lo_in,
  input  logic [31:0]   q_in,
  output logic [DW-1:0] rem,
  output logic [31:0]   lo,
  output logic [31:0]   q
);

  logic [DW:0] r2;
  logic        take;

  // Bring down the next dividend bit and trial-subtract
  always_comb begin
    r2   = {rem_in, lo_in[31]};
    take = (r2 >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? DW'(r2 - {1'b0, d}) : DW'(r2);
      lo  <= {lo_in[30:0], 1'b0};
      q   <= {q_in[30:0], take};
    end
  end

endmodule

// ----- rtl/fwsk_axle.sv -----
// ----------------------------------------------------------------------------
// fwsk_axle
// Steering angle and wheel speed for one axle: normalise, CORDIC vectoring,
// angle finish, CORDIC rotation, gain multiply and a chain of divide cells.
// ----------------------------------------------------------------------------
module fwsk_axle
  import fwsk_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        base_radius,
  input  logic [23:0]        axle_scale,
  input  logic signed [31:0] vx,
  input  logic signed [48:0] n,
  output logic signed [31:0] speed,
  output logic signed [17:0] angle
);

  localparam int S = STAGES;
  localparam logic [29:0] KQ = kq_const(STAGES);

  // Divisor follows the radius registers
  logic [DW-1:0] d_r;
  always_ff @(posedge clk) begin
    d_r <= {48'(base_radius) * 48'(axle_scale), 8'b0};
  end

  // Magnitudes and special-case flags
  axle_meta_t  meta1;
  logic [31:0] ax1;
  logic [48:0] ay1;
  always_ff @(posedge clk) begin
    if (en) begin
      ax1           <= vx[31] ? 32'(-vx) : 32'(vx);
      ay1           <= n[48] ? 49'(-n) : 49'(n);
      meta1.vx      <= vx;
      meta1.n       <= n;
      meta1.zero_n  <= (n == '0);
      meta1.zero_vx <= (vx == '0);
      meta1.neg     <= (n[48] != vx[31]);
    end
  end

  // Normalise in three registered steps of two shifts each
  logic [111:0] p2a, p2b, p3a, p3b, p4a, p4b;
  logic [55:0]  nx2, ny2, nx3, ny3, nx4, ny4;
  always_comb begin
    p2a = norm_step(56'(ax1), 56'(ay1), 32);
    p2b = norm_step(p2a[111:56], p2a[55:0], 16);
    p3a = norm_step(nx2, ny2, 8);
    p3b = norm_step(p3a[111:56], p3a[55:0], 4);
    p4a = norm_step(nx3, ny3, 2);
    p4b = norm_step(p4a[111:56], p4a[55:0], 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {nx2, ny2} <= p2b;
      {nx3, ny3} <= p3b;
      {nx4, ny4} <= p4b;
    end
  end

  // Carry metadata beside the normaliser and the vectoring chain
  axle_meta_t m_line [S+3];
  always_ff @(posedge clk) begin
    if (en) begin
      m_line[0] <= meta1;
      for (int k = 1; k < S + 3; k++) begin
        m_line[k] <= m_line[k-1];
      end
    end
  end

  // Vectoring chain
  logic signed [CW-1:0] vx_c [S+1];
  logic signed [CW-1:0] vy_c [S+1];
  logic signed [ZW-1:0] vz_c [S+1];
  assign vx_c[0] = signed'(CW'(nx4));
  assign vy_c[0] = signed'(CW'(ny4));
  assign vz_c[0] = '0;

  for (genvar i = 0; i < S; i++) begin : g_vec
    fwsk_cordic_cell #(.I(i), .ROTATE(1'b0)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (vx_c[i]),
      .y_in (vy_c[i]),
      .z_in (vz_c[i]),
      .x    (vx_c[i+1]),
      .y    (vy_c[i+1]),
      .z    (vz_c[i+1])
    );
  end

  // Finish the angle: clamp, round, small-angle and sign
  axle_meta_t         mf;
  logic [31:0]        zc;
  logic [16:0]        mag;
  logic [17:0]        mg18;
  logic signed [17:0] th_next;
  always_comb begin
    mf = m_line[S+2];
    if (vz_c[S] < 0) begin
      zc = '0;
    end else if (vz_c[S] > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = vz_c[S];
    end
    if (mf.zero_n) begin
      mag = '0;
    end else if (mf.zero_vx) begin
      mag = HALF_PI_Q16;
    end else begin
      mag = 17'((33'(zc) + 33'd8192) >> 14);
    end
    if (mag <= SMALL_ANGLE_Q16) begin
      mag = '0;
    end
    mg18    = {1'b0, mag};
    th_next = mf.neg ? signed'(~mg18 + 18'd1) : signed'(mg18);
  end

  // Rotation chain seeded with the command and minus the angle
  logic signed [CW-1:0] rx_c [S+1];
  logic signed [CW-1:0] ry_c [S+1];
  logic signed [ZW-1:0] rz_c [S+1];
  logic signed [CW-1:0] rx0;
  logic signed [CW-1:0] ry0;
  logic signed [ZW-1:0] rz0;
  logic signed [17:0]   theta_r;
  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= th_next;
      rx0     <= CW'(mf.vx) <<< 10;
      ry0     <= CW'(mf.n) <<< 10;
      rz0     <= -(ZW'(th_next) <<< 14);
    end
  end

  assign rx_c[0] = rx0;
  assign ry_c[0] = ry0;
  assign rz_c[0] = rz0;

  for (genvar i = 0; i < S; i++) begin : g_rot
    fwsk_cordic_cell #(.I(i), .ROTATE(1'b1)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (rx_c[i]),
      .y_in (ry_c[i]),
      .z_in (rz_c[i]),
      .x    (rx_c[i+1]),
      .y    (ry_c[i+1]),
      .z    (rz_c[i+1])
    );
  end

  // Gain multiply in two partial products
  logic [CW-1:0] pm;
  logic [61:0]   pa_r;
  logic [59:0]   pb_r;
  logic          pneg_r;
  logic          pzero_r;
  assign pm = rx_c[S][CW-1] ? CW'(-rx_c[S]) : CW'(rx_c[S]);
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= 62'(pm[31:0]) * 62'(KQ);
      pb_r    <= 60'(pm[61:32]) * 60'(KQ);
      pneg_r  <= rx_c[S][CW-1];
      pzero_r <= (rx_c[S] == '0);
    end
  end

  // Sum the partials and test for quotient overflow
  logic [92:0]   prod;
  logic [DW-1:0] rem_c [33];
  logic [31:0]   lo_c  [33];
  logic [31:0]   q_c   [33];
  logic [DW-1:0] rem0;
  logic [31:0]   lo0;
  div_flags_t    fl7;
  assign prod = 93'(pa_r) + (93'(pb_r) << 32);
  assign q_c[0] = '0;
  always_ff @(posedge clk) begin
    if (en) begin
      rem0      <= prod[87:32];
      lo0       <= prod[31:0];
      fl7.neg   <= pneg_r;
      fl7.pzero <= pzero_r;
      fl7.sat   <= (d_r == '0) || (prod[92:32] >= 61'(d_r));
    end
  end

  assign rem_c[0] = rem0;
  assign lo_c[0]  = lo0;

  for (genvar i = 0; i < 32; i++) begin : g_div
    fwsk_div_cell u_cell (
      .clk    (clk),
      .en     (en),
      .d      (d_r),
      .rem_in (rem_c[i]),
      .lo_in  (lo_c[i]),
      .q_in   (q_c[i]),
      .rem    (rem_c[i+1]),
      .lo     (lo_c[i+1]),
      .q      (q_c[i+1])
    );
  end

  // Carry angle and flags beside the back end
  logic signed [17:0] th_line [S+34];
  div_flags_t         fl_line [32];
  always_ff @(posedge clk) begin
    if (en) begin
      th_line[0] <= theta_r;
      for (int k = 1; k < S + 34; k++) begin
        th_line[k] <= th_line[k-1];
      end
      fl_line[0] <= fl7;
      for (int k = 1; k < 32; k++) begin
        fl_line[k] <= fl_line[k-1];
      end
    end
  end

  // Saturate and apply the sign
  div_flags_t  ff;
  logic [31:0] limit;
  logic [31:0] qc;
  always_comb begin
    ff    = fl_line[31];
    limit = ff.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qc    = (ff.sat || (q_c[32] > limit)) ? limit : q_c[32];
    if (ff.pzero) begin
      speed = '0;
    end else begin
      speed = ff.neg ? signed'(-qc) : signed'(qc);
    end
    angle = th_line[S+33];
  end

endmodule

// ----- rtl/four_wheel_steer_kinematics_top.sv -----
// Throughput: one command per cycle, set by the fully pipelined CORDIC and
// divide cell chains; the pipe stalls only when the result register is held.
// Reset clears the pipeline valid bits and returns the configuration registers
// to their reset values; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// four_wheel_steer_kinematics_top
// Body velocity command to front and rear steering angles and wheel speeds.
// ----------------------------------------------------------------------------
module four_wheel_steer_kinematics_top
  import fwsk_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fwsk_cmd_if.sink   cmd,
  fwsk_res_if.source res,
  fwsk_cfg_if.sink   cfg
);

  localparam int NV = 2 * CORDIC_STAGES + 42;

  // Configuration registers
  logic        enabled;
  logic [23:0] track_width;
  logic [23:0] track_scale;
  logic [23:0] base_radius;
  logic [23:0] front_radius_scale;
  logic [23:0] rear_radius_scale;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      track_width        <= TRACK_WIDTH_RST;
      track_scale        <= TRACK_SCALE_RST;
      base_radius        <= BASE_RADIUS_RST;
      front_radius_scale <= AXLE_SCALE_RST;
      rear_radius_scale  <= AXLE_SCALE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLED:     enabled            <= cfg.data[0];
        REG_TRACK_WIDTH: track_width        <= cfg.data;
        REG_TRACK_SCALE: track_scale        <= cfg.data;
        REG_BASE_RADIUS: base_radius        <= cfg.data;
        REG_FRONT_SCALE: front_radius_scale <= cfg.data;
        REG_REAR_SCALE:  rear_radius_scale  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective track follows the registers
  logic [31:0] track;
  always_ff @(posedge clk) begin
    track <= 32'((48'(track_width) * 48'(track_scale)) >> 16);
  end

  // Pipeline control: advance unless the result register is held and full while the last stage is valid
  logic          adv;
  logic [NV-1:0] vld;
  logic          out_valid;
  assign adv       = !out_valid || res.ready || !vld[NV-1];
  assign cmd.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], cmd.valid};
    end
  end

  // Capture the command
  logic signed [31:0] vx1, vy1;
  logic [31:0]        wmag1;
  logic               wneg1;
  always_ff @(posedge clk) begin
    if (adv) begin
      vx1   <= cmd.vel_forward;
      vy1   <= cmd.vel_lateral;
      wmag1 <= cmd.yaw_rate[31] ? 32'(-cmd.yaw_rate) : 32'(cmd.yaw_rate);
      wneg1 <= cmd.yaw_rate[31];
    end
  end

  // Yaw term: half track times yaw rate
  logic signed [31:0] vx2, vy2;
  logic signed [47:0] yaw2;
  logic [46:0]        ymag;
  assign ymag = 47'((64'(wmag1) * 64'(track)) >> 17);
  always_ff @(posedge clk) begin
    if (adv) begin
      vx2  <= vx1;
      vy2  <= vy1;
      yaw2 <= wneg1 ? -signed'({1'b0, ymag}) : signed'({1'b0, ymag});
    end
  end

  // Front and rear numerators
  logic signed [31:0] vx3;
  logic signed [48:0] nf3, nr3;
  always_ff @(posedge clk) begin
    if (adv) begin
      vx3 <= vx2;
      nf3 <= 49'(vy2) + 49'(yaw2);
      nr3 <= 49'(vy2) - 49'(yaw2);
    end
  end

  logic signed [31:0] f_speed, r_speed;
  logic signed [17:0] f_angle, r_angle;

  fwsk_axle #(.STAGES(CORDIC_STAGES)) u_front (
    .clk         (clk),
    .en          (adv),
    .base_radius (base_radius),
    .axle_scale  (front_radius_scale),
    .vx          (vx3),
    .n           (nf3),
    .speed       (f_speed),
    .angle       (f_angle)
  );

  fwsk_axle #(.STAGES(CORDIC_STAGES)) u_rear (
    .clk         (clk),
    .en          (adv),
    .base_radius (base_radius),
    .axle_scale  (rear_radius_scale),
    .vx          (vx3),
    .n           (nr3),
    .speed       (r_speed),
    .angle       (r_angle)
  );

  // Result register: load when empty or taken, zero the result fields when disabled
  logic signed [31:0] out_fs, out_rs;
  logic signed [17:0] out_fa, out_ra;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      out_fs <= enabled ? f_speed : '0;
      out_rs <= enabled ? r_speed : '0;
      out_fa <= enabled ? f_angle : '0;
      out_ra <= enabled ? r_angle : '0;
    end
  end

  assign res.valid             = out_valid;
  assign res.front_wheel_speed = out_fs;
  assign res.rear_wheel_speed  = out_rs;
  assign res.front_steer_angle = out_fa;
  assign res.rear_steer_angle  = out_ra;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-wheel-steer kinematics block: a directed
// table and random phases of velocity commands, each result checked field by
// field against an in-bench bit-exact model or a fixed table value under several register settings.
// ----------------------------------------------------------------------------
module tb
  import fwsk_pkg::*;
();

  localparam int STAGES     = CORDIC_STAGES_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_PHASES   = 8;
  localparam int PHASE_LEN  = 140;

  typedef struct packed {
    logic signed [31:0] front_speed;
    logic signed [31:0] rear_speed;
    logic signed [17:0] front_angle;
    logic signed [17:0] rear_angle;
  } steer_out_t;

  typedef struct {
    bit                 en;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] w;
    bit                 typed;
    steer_out_t         want;
  } dir_row_t;

  logic clk;
  logic rst;

  fwsk_cmd_if cmd_ch();
  fwsk_res_if res_ch();
  fwsk_cfg_if cfg_ch();

  four_wheel_steer_kinematics_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // shadow registers
  bit          sh_en;
  logic [23:0] sh_track_w, sh_track_s, sh_radius, sh_front_s, sh_rear_s;

  steer_out_t  steer_expect_q[$];
  bit          cur_typed;
  steer_out_t  cur_want;
  int          fail_cnt;
  int          cmd_cnt, res_cnt, cfg_cnt;
  int          hold_rx;
  bit          no_idle;
  int          idle_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint heading_mag(longint unsigned ax, longint unsigned ay);
    longint x, y, z, xs, ys;
    z = 0;
    if (ay == 0) return 0;
    if (ax == 0) return longint'(HALF_PI_Q16);
    while ((ax | ay) < (64'd1 << 55)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = ax;
    y = ay;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    return (z + 8192) >>> 14;
  endfunction

  function automatic longint project_heading(longint vx, longint n, longint theta);
    longint x, y, z, xs, ys;
    x = vx * 1024;
    y = n * 1024;
    z = -theta * 16384;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end
    end
    return x;
  endfunction

  function automatic logic [31:0] rim_speed(longint p, longint unsigned rraw);
    longint unsigned kq, lim, d, q;
    logic [127:0] prod, q128;
    kq  = 64'd652032874 + ((64'd434688583 + (64'd1 << (2 * STAGES - 1))) >> (2 * STAGES));
    lim = (p < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (p == 0) return 32'd0;
    d = rraw << 8;
    if (d == 0) begin
      q = lim;
    end else begin
      prod = 128'(abs64(p)) * 128'(kq);
      q128 = prod / 128'(d);
      q = (q128 > 128'(lim)) ? lim : q128[63:0];
    end
    return (p < 0) ? 32'(64'd0 - q) : 32'(q);
  endfunction

  function automatic void axle_predict(longint vx, longint n, logic [23:0] scale,
                                       output logic [31:0] speed,
                                       output logic [17:0] angle);
    longint mag, theta;
    mag = heading_mag(abs64(vx), abs64(n));
    if (mag <= longint'(SMALL_ANGLE_Q16)) mag = 0;
    theta = ((n < 0) != (vx < 0)) ? -mag : mag;
    speed = rim_speed(project_heading(vx, n, theta),
                      longint'(sh_radius) * longint'(scale));
    angle = 18'(theta);
  endfunction

  function automatic steer_out_t kinematics_predict(logic signed [31:0] vx_i,
                                                    logic signed [31:0] vy_i,
                                                    logic signed [31:0] w_i);
    steer_out_t o;
    longint unsigned t, ym;
    longint yaw, vx, vy;
    o = '0;
    if (!sh_en) return o;
    vx = vx_i;
    vy = vy_i;
    t  = (longint'(sh_track_w) * longint'(sh_track_s)) >> 16;
    ym = (abs64(longint'(w_i)) * t) >> 17;
    yaw = (w_i < 0) ? -longint'(ym) : longint'(ym);
    axle_predict(vx, vy + yaw, sh_front_s, o.front_speed, o.front_angle);
    axle_predict(vx, vy - yaw, sh_rear_s, o.rear_speed, o.rear_angle);
    return o;
  endfunction

  // ---------------------------------------------------------------- monitors
  // shadow register writes
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      cfg_cnt++;
      case (cfg_ch.index)
        REG_ENABLED:     sh_en      <= cfg_ch.data[0];
        REG_TRACK_WIDTH: sh_track_w <= cfg_ch.data;
        REG_TRACK_SCALE: sh_track_s <= cfg_ch.data;
        REG_BASE_RADIUS: sh_radius  <= cfg_ch.data;
        REG_FRONT_SCALE: sh_front_s <= cfg_ch.data;
        REG_REAR_SCALE:  sh_rear_s  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // queue a prediction for each accepted command
  always @(posedge clk) begin
    steer_out_t pred;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      cmd_cnt++;
      if (cur_typed) pred = cur_want;
      else pred = kinematics_predict(cmd_ch.vel_forward, cmd_ch.vel_lateral,
                                     cmd_ch.yaw_rate);
      steer_expect_q = {steer_expect_q, pred};
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    steer_out_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_cnt++;
      if (steer_expect_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_cnt++;
      end else begin
        e = steer_expect_q.pop_front();
        if (res_ch.front_wheel_speed !== e.front_speed) begin
          $error("front_wheel_speed expected %0d got %0d", e.front_speed,
                 res_ch.front_wheel_speed);
          fail_cnt++;
        end
        if (res_ch.rear_wheel_speed !== e.rear_speed) begin
          $error("rear_wheel_speed expected %0d got %0d", e.rear_speed,
                 res_ch.rear_wheel_speed);
          fail_cnt++;
        end
        if (res_ch.front_steer_angle !== e.front_angle) begin
          $error("front_steer_angle expected %0d got %0d", e.front_angle,
                 res_ch.front_steer_angle);
          fail_cnt++;
        end
        if (res_ch.rear_steer_angle !== e.rear_angle) begin
          $error("rear_steer_angle expected %0d got %0d", e.rear_angle,
                 res_ch.rear_steer_angle);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", steer_expect_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // random back-pressure; a long hold when requested
  initial begin
    int gap;
    gap = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx > 0) begin
        res_ch.ready = 1'b0;
        hold_rx--;
      end else if (gap > 0 && !no_idle) begin
        res_ch.ready = 1'b0;
        gap--;
      end else begin
        res_ch.ready = 1'b1;
        gap = 0;
        if ($urandom_range(0, 6) == 0)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_cmd(logic signed [31:0] vx, logic signed [31:0] vy,
                          logic signed [31:0] w, bit typed, steer_out_t want);
    int gap;
    @(negedge clk);
    cmd_ch.vel_forward = vx;
    cmd_ch.vel_lateral = vy;
    cmd_ch.yaw_rate    = w;
    cur_typed          = typed;
    cur_want           = want;
    cmd_ch.valid       = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold the sender until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (steer_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_vel();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      4: return 32'($urandom_range(0, 20)) - 32'd10;
      5: return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [23:0] rnd_reg();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(1000, 200000));
      default: return 24'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sd65536;

  dir_row_t dir_tab[] = '{
    '{1'b0, MAXV, MAXV, MAXV, 1'b1, '0},   // disabled: zero out
    '{1'b0, MINV, MINV, MINV, 1'b1, '0},
    '{1'b1, 32'sd0, 32'sd0, 32'sd0, 1'b1, '0},  // zero numerator, zero vx
    '{1'b1, ONE, 32'sd0, 32'sd0, 1'b0, '0},
    '{1'b1, 32'sd0, ONE, 32'sd0, 1'b0, '0},     // zero forward speed
    '{1'b1, 32'sd0, -ONE, 32'sd0, 1'b0, '0},
    '{1'b1, -ONE, 32'sd0, 32'sd0, 1'b0, '0},
    '{1'b1, ONE, 32'sd300, 32'sd0, 1'b0, '0},   // below the small-angle cut
    '{1'b1, ONE, 32'sd700, 32'sd0, 1'b0, '0},
    '{1'b1, ONE, 32'sd0, ONE, 1'b0, '0},
    '{1'b1, -ONE, ONE, -ONE, 1'b0, '0},
    '{1'b1, 32'sd0, 32'sd0, ONE, 1'b0, '0},
    '{1'b1, ONE, ONE, 32'sd0, 1'b0, '0},
    '{1'b1, -ONE, -ONE, 32'sd0, 1'b0, '0},
    '{1'b1, MAXV, MAXV, MAXV, 1'b0, '0},
    '{1'b1, MINV, MINV, MINV, 1'b0, '0},
    '{1'b1, MAXV, MINV, MAXV, 1'b0, '0},
    '{1'b1, MINV, MAXV, MINV, 1'b0, '0},
    '{1'b1, 32'sd1, 32'sd1, 32'sd0, 1'b0, '0},
    '{1'b1, 32'sd0, 32'sd1, 32'sd0, 1'b0, '0},
    '{1'b1, 32'sd0, 32'sd0, MINV, 1'b0, '0},
    '{1'b1, 32'sd1, MAXV, 32'sd0, 1'b0, '0}
  };

  initial begin
    logic [23:0] r;
    fail_cnt = 0;
    cmd_cnt = 0;
    res_cnt = 0;
    cfg_cnt = 0;
    hold_rx = 0;
    no_idle = 1'b0;
    sh_en = 1'b0;
    sh_track_w = TRACK_WIDTH_RST;
    sh_track_s = TRACK_SCALE_RST;
    sh_radius  = BASE_RADIUS_RST;
    sh_front_s = AXLE_SCALE_RST;
    sh_rear_s  = AXLE_SCALE_RST;
    cmd_ch.valid = 1'b0;
    cmd_ch.vel_forward = '0;
    cmd_ch.vel_lateral = '0;
    cmd_ch.yaw_rate = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // out of range indexes are ignored
    cfg_write(3'd6, 24'hFF_FFFF);
    cfg_write(3'd7, 24'h00_0001);

    // walk the directed table; toggle enable between rows when needed
    foreach (dir_tab[k]) begin
      if (dir_tab[k].en != sh_en) begin
        drain();
        cfg_write(REG_ENABLED, 24'(dir_tab[k].en));
      end
      send_cmd(dir_tab[k].vx, dir_tab[k].vy, dir_tab[k].w, dir_tab[k].typed,
               dir_tab[k].want);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      cfg_write(REG_ENABLED, (ph == 4) ? 24'd0 : 24'd1);
      case (ph)
        0: begin
          cfg_write(REG_TRACK_WIDTH, TRACK_WIDTH_RST);
          cfg_write(REG_BASE_RADIUS, 24'd6554);
        end
        1: cfg_write(REG_BASE_RADIUS, 24'd0);  // zero radius saturates
        2: begin
          cfg_write(REG_TRACK_WIDTH, 24'hFF_FFFF);
          cfg_write(REG_TRACK_SCALE, 24'hFF_FFFF);
          cfg_write(REG_BASE_RADIUS, 24'hFF_FFFF);
          cfg_write(REG_FRONT_SCALE, 24'hFF_FFFF);
          cfg_write(REG_REAR_SCALE, 24'hFF_FFFF);
        end
        3: begin
          cfg_write(REG_TRACK_WIDTH, 24'd0);
          cfg_write(REG_BASE_RADIUS, 24'd1);
          cfg_write(REG_FRONT_SCALE, 24'd1);
          cfg_write(REG_REAR_SCALE, 24'd65536);
        end
        5: begin
          cfg_write(REG_TRACK_WIDTH, 24'd40000);
          cfg_write(REG_TRACK_SCALE, 24'd65536);
          cfg_write(REG_BASE_RADIUS, 24'd6554);
          cfg_write(REG_FRONT_SCALE, 24'd0);
          cfg_write(REG_REAR_SCALE, 24'hFF_FFFF);
        end
        default: begin
          for (int ri = 1; ri <= 5; ri++) begin
            r = rnd_reg();
            cfg_write(3'(ri), r);
          end
        end
      endcase
      no_idle = (ph == 6);
      // long receiver hold while the sender keeps offering
      if (ph == 2) hold_rx = 400;
      for (int k = 0; k < PHASE_LEN; k++)
        send_cmd(rnd_vel(), rnd_vel(), rnd_vel(), 1'b0, '0);
    end

    // wait for the tail, then settle
    drain();
    repeat (2 * STAGES + 60) @(posedge clk);

    $display("covered %0d commands, %0d results, %0d register writes over %0d phases",
             cmd_cnt, res_cnt, cfg_cnt, N_PHASES);
    $display("settings included zero and full-scale track, radius and axle scales");
    if (fail_cnt == 0 && steer_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, steer_expect_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
